>>> design/udp_client_session_table_top_assert.svh
// ---------------------------------------------------------------------------
// Session table assertion macros
// Shared concurrent assertion forms, clocked on clk and idle while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UDP_CLIENT_SESSION_TABLE_TOP_ASSERT_SVH
`define UDP_CLIENT_SESSION_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ucst_pkg.sv
// ---------------------------------------------------------------------------
// Session table package
// Shared constants and the slot entry layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucst_pkg;

  // Default number of slots.
  localparam int unsigned SLOT_COUNT_DEF = 16;

  // Header values that select a served frame.
  localparam logic [15:0] ETHER_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  // A disconnect keyword needs ten payload bytes behind the header.
  localparam logic [15:0] KEY_MIN_LEN = 16'd18;

  // The ASCII keyword "disconnect", split into head and tail.
  localparam logic [63:0] KEY_HEAD = 64'h6469_7363_6F6E_6E65;
  localparam logic [15:0] KEY_TAIL = 16'h6374;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_IGNORED      = 2'd0,
    ST_ECHO         = 2'd1,
    ST_DISCONNECTED = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  // One slot of the table as stored in memory.
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] count;
  } entry_t;

endpackage

>>> design/udp_client_session_table_top.sv
// ---------------------------------------------------------------------------
// UDP client session table
// Tracks UDP senders in a slot table held in RAM, counts their requests and
// recognizes the disconnect keyword.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ---------------------------------
//   in        start high, busy low      in_ether_type .. in_payload_tail
//   out       out_strobe, one cycle     out_status .. out_message_count
//   cfg       cfg_wr_en                 cfg_wr_data (listen port)
//
// A frame that is not served gives its result in the cycle after acceptance
// and leaves busy low. A served frame scans the table: one slot is read
// from the table RAM per cycle, then the commit state decides and writes
// back, and busy stays high until then.
// Reset is synchronous; it empties the table by clearing the per-slot
// valid bits, so no clearing pass is needed.
// The receiver cannot hold off results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "udp_client_session_table_top_assert.svh"

module udp_client_session_table_top #(
  parameter int unsigned SLOT_COUNT = ucst_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_udp_length,
  input  logic [31:0] in_source_addr,
  input  logic [15:0] in_source_port,
  input  logic [63:0] in_payload_head,
  input  logic [15:0] in_payload_tail,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_new_connection,
  output logic [3:0]  out_slot_index,
  output logic [31:0] out_message_count,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import ucst_pkg::*;

  localparam int unsigned SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned XW   = (SW > 4) ? SW : 4;
  localparam int unsigned EW   = $bits(entry_t);
  localparam logic [SW:0]   NSLOT = (SW + 1)'(SLOT_COUNT);
  localparam logic [SW-1:0] LAST  = SW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t          state_r;
  logic [15:0]     listen_port_r;
  logic [SLOT_COUNT-1:0] valid_r;

  // Request being worked on.
  logic [31:0]     saddr_r;
  logic [15:0]     sport_r;
  logic            quit_r;

  // Scan bookkeeping.
  logic [SW:0]     issue_r;
  logic            pend_r;
  logic [SW-1:0]   pend_idx_r;
  logic            found_r;
  logic [SW-1:0]   match_idx_r;
  logic [31:0]     match_cnt_r;
  logic            efound_r;
  logic [SW-1:0]   empty_idx_r;

  // Result registers.
  logic            out_strobe_r;
  status_t         out_status_r;
  logic            out_new_r;
  logic [3:0]      out_idx_r;
  logic [31:0]     out_cnt_r;

  // RAM signals.
  logic            ram_we;
  logic [SW-1:0]   ram_raddr;
  entry_t          ram_wdata;
  logic [EW-1:0]   ram_rdata;
  logic [SW-1:0]   slot_sel;

  ucst_ram #(
    .WIDTH (EW),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_sel),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Frame filter on the raw input ports.
  logic accept;
  logic served;
  logic quit_in;

  assign accept  = start && (state_r == S_IDLE);
  assign served  = (in_ether_type == ETHER_IPV4) && (in_ip_protocol == PROTO_UDP) &&
                   (in_dest_port == listen_port_r) && (in_udp_length > UDP_HDR_LEN);
  assign quit_in = (in_udp_length >= KEY_MIN_LEN) && (in_payload_head == KEY_HEAD) &&
                   (in_payload_tail == KEY_TAIL);

  // Slot read back from RAM; a slot never written since reset reads as zero.
  entry_t rd_entry;
  logic   rd_occupied;
  logic   rd_match;

  assign rd_entry    = valid_r[pend_idx_r] ? entry_t'(ram_rdata) : '0;
  assign rd_occupied = (rd_entry.addr != '0);
  assign rd_match    = rd_occupied && (rd_entry.addr == saddr_r) &&
                       (rd_entry.port == sport_r);

  assign ram_raddr = issue_r[SW-1:0];

  // Decision for the commit cycle.
  logic          table_full;
  logic [31:0]   cur_cnt;
  logic [31:0]   inc_cnt;
  logic [XW-1:0] slot_ext;

  assign table_full = !found_r && !efound_r;
  assign slot_sel   = found_r ? match_idx_r : empty_idx_r;
  assign cur_cnt    = found_r ? match_cnt_r : '0;
  assign inc_cnt    = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 32'd1;
  assign slot_ext   = XW'(slot_sel);

  assign ram_we         = (state_r == S_COMMIT) && !table_full && !quit_r;
  assign ram_wdata.addr  = saddr_r;
  assign ram_wdata.port  = sport_r;
  assign ram_wdata.count = inc_cnt;

  // Sequencer, table valid bits and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      listen_port_r <= '0;
      valid_r       <= '0;
      out_strobe_r  <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr_en) begin
        listen_port_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            saddr_r  <= in_source_addr;
            sport_r  <= in_source_port;
            quit_r   <= quit_in;
            issue_r  <= '0;
            pend_r   <= 1'b0;
            found_r  <= 1'b0;
            efound_r <= 1'b0;
            if (served) begin
              state_r <= S_SCAN;
            end else begin
              out_strobe_r <= 1'b1;
              out_status_r <= ST_IGNORED;
              out_new_r    <= 1'b0;
              out_idx_r    <= '0;
              out_cnt_r    <= '0;
            end
          end
        end
        S_SCAN: begin
          // Issue one read a cycle and examine the slot read the cycle before.
          if (issue_r < NSLOT) begin
            issue_r <= issue_r + 1'b1;
          end
          pend_r     <= (issue_r < NSLOT);
          pend_idx_r <= issue_r[SW-1:0];
          if (pend_r) begin
            if (rd_match && !found_r) begin
              found_r     <= 1'b1;
              match_idx_r <= pend_idx_r;
              match_cnt_r <= rd_entry.count;
            end
            if (!rd_occupied && !efound_r) begin
              efound_r    <= 1'b1;
              empty_idx_r <= pend_idx_r;
            end
            if (pend_idx_r == LAST) begin
              state_r <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          state_r      <= S_IDLE;
          out_strobe_r <= 1'b1;
          if (table_full) begin
            out_status_r <= ST_FULL;
            out_new_r    <= 1'b0;
            out_idx_r    <= '0;
            out_cnt_r    <= '0;
          end else begin
            out_new_r <= !found_r;
            out_idx_r <= slot_ext[3:0];
            if (quit_r) begin
              // A disconnect empties the slot in every case.
              valid_r[slot_sel] <= 1'b0;
              out_status_r      <= ST_DISCONNECTED;
              out_cnt_r         <= cur_cnt;
            end else begin
              valid_r[slot_sel] <= 1'b1;
              out_status_r      <= ST_ECHO;
              out_cnt_r         <= inc_cnt;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_new_connection = out_new_r;
  assign out_slot_index     = out_idx_r;
  assign out_message_count  = out_cnt_r;

  // Checks on the sequencer and on result consistency.
  `UCST_ASSERT_NEXT(a_ignored_result, accept && !served,
                    out_strobe && (out_status == ST_IGNORED), "ignored frame gave no result")
  `UCST_ASSERT_NEXT(a_served_busy, accept && served, busy && !out_strobe,
                    "served frame did not start a scan")
  `UCST_ASSERT_NEXT(a_commit_result, state_r == S_COMMIT, out_strobe && !busy,
                    "commit cycle gave no result")
  `UCST_ASSERT_SAME(a_full_zero, out_strobe && (out_status == ST_FULL),
                    !out_new_connection && (out_slot_index == '0) && (out_message_count == '0),
                    "table full result carries data")
  `UCST_ASSERT_SAME(a_new_conn_status, out_strobe && out_new_connection,
                    (out_status == ST_ECHO) || (out_status == ST_DISCONNECTED),
                    "new connection flagged on a frame that took no slot")

endmodule

>>> design/ucst_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
